// ===== design/chroma_key_alpha_macros.svh =====
// Assertion macros shared by the chroma key checker.
`ifndef CHROMA_KEY_ALPHA_MACROS_SVH
`define CHROMA_KEY_ALPHA_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CKA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold once the delay n has passed after the antecedent.
`define CKA_ASSERT_AFTER(lbl, clk, rstn, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ===== design/ck_alpha_pkg.sv =====
// Package with widths, codes and types shared by the chroma key design.
package ck_alpha_pkg;

  localparam int CHAN_W    = 8;
  localparam int REG_IDX_W = 3;
  localparam int SQ_W      = 2 * CHAN_W;
  localparam int REACH_W   = CHAN_W + 1;
  localparam int DIST_W    = 18;
  localparam int OUTER_W   = 20;
  localparam int DEN_W     = OUTER_W;
  localparam int NUM_W     = 28;
  localparam int DIV_STEPS = CHAN_W;
  localparam int FRONT_STAGES = 5;
  localparam int CK_LATENCY   = FRONT_STAGES + DIV_STEPS + 1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_KEY_RED   = 3'd0,
    REG_KEY_GREEN = 3'd1,
    REG_KEY_BLUE  = 3'd2,
    REG_TOLERANCE = 3'd3,
    REG_SMOOTHING = 3'd4
  } ck_reg_t;

  typedef enum logic [1:0] {
    SEL_CLEAR = 2'd0,
    SEL_SCALE = 2'd1,
    SEL_KEEP  = 2'd2
  } ck_sel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] alpha;
    ck_sel_t           sel;
  } ck_pix_t;

  localparam logic [CHAN_W-1:0] KEY_RED_RST   = 8'd0;
  localparam logic [CHAN_W-1:0] KEY_GREEN_RST = 8'd255;
  localparam logic [CHAN_W-1:0] KEY_BLUE_RST  = 8'd0;
  localparam logic [CHAN_W-1:0] TOL_RST       = 8'd26;
  localparam logic [CHAN_W-1:0] SMOOTH_RST    = 8'd26;

endpackage

// ===== design/ck_alpha_div.sv =====
// Pipelined restoring divider producing one quotient bit per stage.
module ck_alpha_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             div_valid,
  input  logic [ck_alpha_pkg::NUM_W-1:0]   div_num,
  input  logic [ck_alpha_pkg::DEN_W-1:0]   div_den,
  input  ck_alpha_pkg::ck_pix_t            div_side,
  output logic                             quot_valid,
  output logic [ck_alpha_pkg::DIV_STEPS-1:0] quot,
  output ck_alpha_pkg::ck_pix_t            quot_side
);
  import ck_alpha_pkg::*;

  logic                 v_in   [DIV_STEPS];
  logic [NUM_W-1:0]     rem_in [DIV_STEPS];
  logic [DEN_W-1:0]     den_in [DIV_STEPS];
  logic [DIV_STEPS-1:0] q_in   [DIV_STEPS];
  ck_pix_t              sd_in  [DIV_STEPS];

  logic                 v_r    [DIV_STEPS];
  logic [NUM_W-1:0]     rem_r  [DIV_STEPS];
  logic [DEN_W-1:0]     den_r  [DIV_STEPS];
  logic [DIV_STEPS-1:0] q_r    [DIV_STEPS];
  ck_pix_t              sd_r   [DIV_STEPS];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    localparam int SH = DIV_STEPS - 1 - i;
    logic [NUM_W:0]   den_sh;
    logic [NUM_W:0]   trial;
    logic             ge;
    logic [NUM_W-1:0] rem_nxt;

    if (i == 0) begin : g_first
      assign v_in[i]   = div_valid;
      assign rem_in[i] = div_num;
      assign den_in[i] = div_den;
      assign q_in[i]   = '0;
      assign sd_in[i]  = div_side;
    end else begin : g_next
      assign v_in[i]   = v_r[i-1];
      assign rem_in[i] = rem_r[i-1];
      assign den_in[i] = den_r[i-1];
      assign q_in[i]   = q_r[i-1];
      assign sd_in[i]  = sd_r[i-1];
    end

    // The shifted divisor always fits, so a borrow means the bit is zero.
    assign den_sh  = {{(NUM_W + 1 - DEN_W){1'b0}}, den_in[i]} << SH;
    assign trial   = {1'b0, rem_in[i]} - den_sh;
    assign ge      = ~trial[NUM_W];
    assign rem_nxt = ge ? trial[NUM_W-1:0] : rem_in[i];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_in[i];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i] <= rem_nxt;
      den_r[i] <= den_in[i];
      q_r[i]   <= {q_in[i][DIV_STEPS-2:0], ge};
      sd_r[i]  <= sd_in[i];
    end
  end

  assign quot_valid = v_r[DIV_STEPS-1];
  assign quot       = q_r[DIV_STEPS-1];
  assign quot_side  = sd_r[DIV_STEPS-1];

endmodule

// ===== design/chroma_key_alpha.sv =====
// Soft chroma key on one BGRA pixel per clock: top level with the front pipeline.
//
// Each transaction on the input side is one BGRA pixel, taken at every rising edge where
// start is high and busy is low. busy is high only while reset is asserted, so after reset
// the block can take a pixel in every cycle. The keyed pixel appears on the out_ ports for
// exactly one cycle, marked by out_strobe: five stages compute the squared distance to the
// key color, the two thresholds, the region select and the divider operands, eight stages
// of a restoring divider produce one quotient bit each, and one stage registers
// the result. Results come out in input order and the receiver cannot stall them, so a
// consumer must take out_ data in the cycle out_strobe is high. The color bytes pass
// through unchanged. The alpha is cleared inside the inner radius 3*tol^2, scaled by
// (dist - inner) / (outer - inner), truncated, inside the outer radius
// 3*(tol + smooth)^2, and left alone beyond it. The five key registers are written through
// the cfg_ port, which is always ready; writes to indexes past the smoothing register are
// dropped. Registers should only be changed while no pixel is in flight.
module chroma_key_alpha (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [ck_alpha_pkg::CHAN_W-1:0]      in_blue,
  input  logic [ck_alpha_pkg::CHAN_W-1:0]      in_green,
  input  logic [ck_alpha_pkg::CHAN_W-1:0]      in_red,
  input  logic [ck_alpha_pkg::CHAN_W-1:0]      in_alpha,
  output logic                                 out_strobe,
  output logic [ck_alpha_pkg::CHAN_W-1:0]      out_blue,
  output logic [ck_alpha_pkg::CHAN_W-1:0]      out_green,
  output logic [ck_alpha_pkg::CHAN_W-1:0]      out_red,
  output logic [ck_alpha_pkg::CHAN_W-1:0]      out_alpha,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ck_alpha_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [ck_alpha_pkg::CHAN_W-1:0]      cfg_data
);
  import ck_alpha_pkg::*;

  // Configuration registers.
  logic [CHAN_W-1:0] key_red_r, key_green_r, key_blue_r, tol_r, smooth_r;

  // The block never pushes back except while held in reset.
  assign busy      = ~rst_n;
  assign cfg_ready = 1'b1;

  logic accept;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_red_r   <= KEY_RED_RST;
      key_green_r <= KEY_GREEN_RST;
      key_blue_r  <= KEY_BLUE_RST;
      tol_r       <= TOL_RST;
      smooth_r    <= SMOOTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (ck_reg_t'(cfg_index))
        REG_KEY_RED:   key_red_r   <= cfg_data;
        REG_KEY_GREEN: key_green_r <= cfg_data;
        REG_KEY_BLUE:  key_blue_r  <= cfg_data;
        REG_TOLERANCE: tol_r       <= cfg_data;
        REG_SMOOTHING: smooth_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: absolute channel differences and the outer reach.
  logic              s1_v_r;
  logic [CHAN_W-1:0] s1_dr_r, s1_dg_r, s1_db_r, s1_tol_r;
  logic [REACH_W-1:0] s1_reach_r;
  logic [CHAN_W-1:0] s1_b_r, s1_g_r, s1_r_r, s1_a_r;
  logic [CHAN_W-1:0] dr_nxt, dg_nxt, db_nxt;

  assign dr_nxt = (in_red >= key_red_r) ? in_red - key_red_r : key_red_r - in_red;
  assign dg_nxt = (in_green >= key_green_r) ? in_green - key_green_r
                                            : key_green_r - in_green;
  assign db_nxt = (in_blue >= key_blue_r) ? in_blue - key_blue_r : key_blue_r - in_blue;

  // Stage 2: squares.
  logic              s2_v_r;
  logic [SQ_W-1:0]   s2_sr_r, s2_sg_r, s2_sb_r, s2_tol2_r;
  logic [DIST_W-1:0] s2_reach2_r;
  logic [CHAN_W-1:0] s2_b_r, s2_g_r, s2_r_r, s2_a_r;

  // Stage 3: distance and both thresholds.
  logic               s3_v_r;
  logic [DIST_W-1:0]  s3_dist_r, s3_inner_r;
  logic [OUTER_W-1:0] s3_outer_r;
  logic [CHAN_W-1:0]  s3_b_r, s3_g_r, s3_r_r, s3_a_r;
  logic [DIST_W-1:0]  dist_nxt, inner_nxt;
  logic [OUTER_W-1:0] outer_nxt;

  assign dist_nxt  = DIST_W'(s2_sr_r) + DIST_W'(s2_sg_r) + DIST_W'(s2_sb_r);
  assign inner_nxt = {1'b0, s2_tol2_r, 1'b0} + DIST_W'(s2_tol2_r);
  assign outer_nxt = {1'b0, s2_reach2_r, 1'b0} + OUTER_W'(s2_reach2_r);

  // Stage 4: region select, numerator term and divisor.
  logic              s4_v_r;
  ck_sel_t           s4_sel_r;
  logic [DIST_W-1:0] s4_diff_r;
  logic [DEN_W-1:0]  s4_den_r;
  logic [CHAN_W-1:0] s4_b_r, s4_g_r, s4_r_r, s4_a_r;
  ck_sel_t           sel_nxt;

  always_comb begin
    if (s3_dist_r < s3_inner_r) begin
      sel_nxt = SEL_CLEAR;
    end else if (OUTER_W'(s3_dist_r) < s3_outer_r) begin
      sel_nxt = SEL_SCALE;
    end else begin
      sel_nxt = SEL_KEEP;
    end
  end

  // Stage 5: numerator product.
  logic             s5_v_r;
  logic [NUM_W-1:0] s5_num_r;
  logic [DEN_W-1:0] s5_den_r;
  ck_pix_t          s5_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_dr_r     <= dr_nxt;
    s1_dg_r     <= dg_nxt;
    s1_db_r     <= db_nxt;
    s1_tol_r    <= tol_r;
    s1_reach_r  <= REACH_W'(tol_r) + REACH_W'(smooth_r);
    s1_b_r      <= in_blue;
    s1_g_r      <= in_green;
    s1_r_r      <= in_red;
    s1_a_r      <= in_alpha;

    s2_sr_r     <= SQ_W'(s1_dr_r) * SQ_W'(s1_dr_r);
    s2_sg_r     <= SQ_W'(s1_dg_r) * SQ_W'(s1_dg_r);
    s2_sb_r     <= SQ_W'(s1_db_r) * SQ_W'(s1_db_r);
    s2_tol2_r   <= SQ_W'(s1_tol_r) * SQ_W'(s1_tol_r);
    s2_reach2_r <= DIST_W'(s1_reach_r) * DIST_W'(s1_reach_r);
    s2_b_r      <= s1_b_r;
    s2_g_r      <= s1_g_r;
    s2_r_r      <= s1_r_r;
    s2_a_r      <= s1_a_r;

    s3_dist_r   <= dist_nxt;
    s3_inner_r  <= inner_nxt;
    s3_outer_r  <= outer_nxt;
    s3_b_r      <= s2_b_r;
    s3_g_r      <= s2_g_r;
    s3_r_r      <= s2_r_r;
    s3_a_r      <= s2_a_r;

    s4_sel_r    <= sel_nxt;
    s4_diff_r   <= s3_dist_r - s3_inner_r;
    s4_den_r    <= s3_outer_r - OUTER_W'(s3_inner_r);
    s4_b_r      <= s3_b_r;
    s4_g_r      <= s3_g_r;
    s4_r_r      <= s3_r_r;
    s4_a_r      <= s3_a_r;

    s5_num_r    <= NUM_W'(s4_a_r) * NUM_W'(s4_diff_r);
    s5_den_r    <= s4_den_r;
    s5_side_r   <= '{blue: s4_b_r, green: s4_g_r, red: s4_r_r, alpha: s4_a_r,
                     sel: s4_sel_r};
  end

  // Divider: eight stages, one quotient bit each. The quotient is only used in the
  // scaled region, where it never exceeds the input alpha.
  logic                 div_v;
  logic [DIV_STEPS-1:0] div_q;
  ck_pix_t              div_side;

  ck_alpha_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .div_valid  (s5_v_r),
    .div_num    (s5_num_r),
    .div_den    (s5_den_r),
    .div_side   (s5_side_r),
    .quot_valid (div_v),
    .quot       (div_q),
    .quot_side  (div_side)
  );

  // Output register: choose the final alpha.
  logic              out_v_r;
  logic [CHAN_W-1:0] out_b_r, out_g_r, out_r_r, out_a_r;
  logic [CHAN_W-1:0] alpha_nxt;

  always_comb begin
    case (div_side.sel)
      SEL_CLEAR: alpha_nxt = '0;
      SEL_SCALE: alpha_nxt = CHAN_W'(div_q);
      default:   alpha_nxt = div_side.alpha;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= div_v;
    end
  end

  always_ff @(posedge clk) begin
    out_b_r <= div_side.blue;
    out_g_r <= div_side.green;
    out_r_r <= div_side.red;
    out_a_r <= alpha_nxt;
  end

  assign out_strobe = out_v_r;
  assign out_blue   = out_b_r;
  assign out_green  = out_g_r;
  assign out_red    = out_r_r;
  assign out_alpha  = out_a_r;

endmodule

// ===== design/chroma_key_alpha_checker.sv =====
// Port-level checker for the chroma key block and its bind to the top level.
`include "chroma_key_alpha_macros.svh"

module chroma_key_alpha_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic [ck_alpha_pkg::CHAN_W-1:0] in_blue,
  input logic [ck_alpha_pkg::CHAN_W-1:0] in_green,
  input logic [ck_alpha_pkg::CHAN_W-1:0] in_red,
  input logic [ck_alpha_pkg::CHAN_W-1:0] in_alpha,
  input logic                            out_strobe,
  input logic [ck_alpha_pkg::CHAN_W-1:0] out_blue,
  input logic [ck_alpha_pkg::CHAN_W-1:0] out_green,
  input logic [ck_alpha_pkg::CHAN_W-1:0] out_red,
  input logic [ck_alpha_pkg::CHAN_W-1:0] out_alpha
);
  import ck_alpha_pkg::*;

  logic accept;
  assign accept = start & ~busy;

  // Every accepted pixel produces exactly one result after the fixed latency.
  `CKA_ASSERT_AFTER(a_result_follows, clk, rst_n, accept, CK_LATENCY, out_strobe, "result missing after accepted pixel")

  // No result appears without a matching transaction on the input side.
  `CKA_ASSERT_SAME(a_no_spurious, clk, rst_n, out_strobe, $past(accept, CK_LATENCY), "result without an accepted pixel")

  // Color bytes are carried unchanged through the pipeline.
  `CKA_ASSERT_SAME(a_colors_pass, clk, rst_n, out_strobe, (out_red == $past(in_red, CK_LATENCY)) && (out_green == $past(in_green, CK_LATENCY)) && (out_blue == $past(in_blue, CK_LATENCY)), "color bytes changed")

  // Keying can only lower the alpha, never raise it.
  `CKA_ASSERT_SAME(a_alpha_not_raised, clk, rst_n, out_strobe, out_alpha <= $past(in_alpha, CK_LATENCY), "alpha above input alpha")

endmodule

bind chroma_key_alpha chroma_key_alpha_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_blue    (in_blue),
  .in_green   (in_green),
  .in_red     (in_red),
  .in_alpha   (in_alpha),
  .out_strobe (out_strobe),
  .out_blue   (out_blue),
  .out_green  (out_green),
  .out_red    (out_red),
  .out_alpha  (out_alpha)
);

// ===== tb/chroma_key_alpha_tb.sv =====
// Self-checking testbench for the chroma_key_alpha soft chroma key block.
`timescale 1ns / 100ps

module chroma_key_alpha_tb;
  import ck_alpha_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 3;
  // The longest legal quiet stretch is a sender gap plus the pipeline latency, or the
  // settling pause between phases; this bound is far above either.
  localparam int STALL_LIMIT  = 2000;
  localparam int PRINT_LIMIT  = 100;

  // Register indexes past the smoothing register, which the block must drop.
  localparam logic [REG_IDX_W-1:0] FIRST_UNUSED_IDX = REG_IDX_W'(int'(REG_SMOOTHING) + 1);
  localparam logic [REG_IDX_W-1:0] LAST_UNUSED_IDX  = REG_IDX_W'((1 << REG_IDX_W) - 1);

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] alpha;
  } pixel_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  logic [CHAN_W-1:0]    in_blue   = '0;
  logic [CHAN_W-1:0]    in_green  = '0;
  logic [CHAN_W-1:0]    in_red    = '0;
  logic [CHAN_W-1:0]    in_alpha  = '0;
  logic                 out_strobe;
  logic [CHAN_W-1:0]    out_blue;
  logic [CHAN_W-1:0]    out_green;
  logic [CHAN_W-1:0]    out_red;
  logic [CHAN_W-1:0]    out_alpha;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CHAN_W-1:0]    cfg_data  = '0;

  chroma_key_alpha u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_blue    (in_blue),
    .in_green   (in_green),
    .in_red     (in_red),
    .in_alpha   (in_alpha),
    .out_strobe (out_strobe),
    .out_blue   (out_blue),
    .out_green  (out_green),
    .out_red    (out_red),
    .out_alpha  (out_alpha),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Pixels waiting to be sent, and keyed pixels the block still owes us, oldest first.
  pixel_t pending_pixels[$];
  pixel_t keyed_expect[$];

  // Our own copy of the key registers, updated when a write transaction is accepted.
  logic [CHAN_W-1:0] key_red      = KEY_RED_RST;
  logic [CHAN_W-1:0] key_green    = KEY_GREEN_RST;
  logic [CHAN_W-1:0] key_blue     = KEY_BLUE_RST;
  logic [CHAN_W-1:0] tol_level    = TOL_RST;
  logic [CHAN_W-1:0] smooth_level = SMOOTH_RST;

  int   mismatch_count = 0;
  int   quiet_cycles   = 0;
  logic took_item      = 1'b0;
  int   burst_left     = 1;
  int   gap_left       = 0;

  // Works out the keyed pixel from the current key registers. All arithmetic is done in
  // wide unsigned integers so that nothing can wrap: the squared distance needs 18 bits,
  // the outer radius 20 and the scaled numerator 26.
  function automatic pixel_t key_pixel(pixel_t px);
    int unsigned dr, dg, db, dist_sq, reach, inner, outer;
    longint unsigned scaled;
    pixel_t keyed;
    dr = (px.red   >= key_red)   ? 32'(px.red   - key_red)   : 32'(key_red   - px.red);
    dg = (px.green >= key_green) ? 32'(px.green - key_green) : 32'(key_green - px.green);
    db = (px.blue  >= key_blue)  ? 32'(px.blue  - key_blue)  : 32'(key_blue  - px.blue);
    dist_sq = dr * dr + dg * dg + db * db;
    reach = int'(tol_level) + int'(smooth_level);
    inner = 3 * int'(tol_level) * int'(tol_level);
    outer = 3 * reach * reach;
    keyed = px;
    if (dist_sq < inner) begin
      keyed.alpha = '0;
    end else if (dist_sq < outer) begin
      // outer > dist_sq >= inner here, so the divisor is never zero.
      scaled = (longint'(px.alpha) * longint'(dist_sq - inner)) / longint'(outer - inner);
      keyed.alpha = scaled[CHAN_W-1:0];
    end
    return keyed;
  endfunction

  // Prints one line per mismatch (up to a cap, to keep the log readable) and counts it.
  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  task automatic check_byte(input string name, input logic [CHAN_W-1:0] got,
                            input logic [CHAN_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  // Monitor. Everything is sampled at the rising edge, where inputs driven at the falling
  // edge have long settled and the block's own updates have not yet landed.
  always @(posedge clk) begin : monitor
    pixel_t sent;
    pixel_t want;
    took_item <= start && !busy;

    // A register write transaction updates our copy of the key registers. The index
    // decode drops anything past the smoothing register, as the block must.
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_RED:   key_red      = cfg_data;
        REG_KEY_GREEN: key_green    = cfg_data;
        REG_KEY_BLUE:  key_blue     = cfg_data;
        REG_TOLERANCE: tol_level    = cfg_data;
        REG_SMOOTHING: smooth_level = cfg_data;
        default: ;
      endcase
    end

    // Each accepted pixel transaction owes exactly one keyed pixel.
    if (start && !busy) begin
      sent = '{blue: in_blue, green: in_green, red: in_red, alpha: in_alpha};
      keyed_expect.push_back(key_pixel(sent));
    end

    // Results cannot be held off, so every strobe is a result transaction.
    if (out_strobe === 1'b1) begin
      if (keyed_expect.size() == 0) begin
        report_mismatch("keyed pixel with no pixel outstanding");
      end else begin
        want = keyed_expect.pop_front();
        check_byte("out_blue",  out_blue,  want.blue);
        check_byte("out_green", out_green, want.green);
        check_byte("out_red",   out_red,   want.red);
        check_byte("out_alpha", out_alpha, want.alpha);
      end
    end

    if ((start && !busy) || out_strobe === 1'b1 || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: a run that stops moving for too long has hung.
  always @(posedge clk) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Driver. A pixel stays on the inputs until it is accepted. The sender works in bursts
  // of random length; after each burst it may rest for a random gap, and about a quarter
  // of the bursts run straight into the next with no gap at all. start is assigned once
  // per falling edge so that back-to-back pixels keep it high without a glitch.
  always @(negedge clk) begin : driver
    logic drive;
    pixel_t px;
    drive = start && !took_item;
    if (!drive) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_pixels.size() > 0) begin
        px = pending_pixels.pop_front();
        in_blue  <= px.blue;
        in_green <= px.green;
        in_red   <= px.red;
        in_alpha <= px.alpha;
        drive = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
      if (!drive) begin
        // Idle inputs carry noise so that a block sampling without start shows up.
        in_blue  <= CHAN_W'($urandom_range(0, 255));
        in_green <= CHAN_W'($urandom_range(0, 255));
        in_red   <= CHAN_W'($urandom_range(0, 255));
        in_alpha <= CHAN_W'($urandom_range(0, 255));
      end
    end
    start <= drive;
  end

  // One register write transaction, driven at the falling edge and held until accepted.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CHAN_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_key(input logic [CHAN_W-1:0] kr, kg, kb, tol, smooth);
    write_reg(REG_KEY_RED,   kr);
    write_reg(REG_KEY_GREEN, kg);
    write_reg(REG_KEY_BLUE,  kb);
    write_reg(REG_TOLERANCE, tol);
    write_reg(REG_SMOOTHING, smooth);
  endtask

  task automatic add_pixel(input logic [CHAN_W-1:0] b, g, r, a);
    pending_pixels.push_back('{blue: b, green: g, red: r, alpha: a});
  endtask

  // A byte within span steps of the key channel, clamped to the byte range.
  function automatic logic [CHAN_W-1:0] near_channel(input int key, input int span);
    int v;
    v = key + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[CHAN_W-1:0];
  endfunction

  // Random pixels. Uniform colors almost always land far from the key, so most pixels
  // are drawn around the key within the soft-edge reach, where the clear, scale and keep
  // decisions all happen. Alpha favors its extremes now and then.
  task automatic add_random(input int count);
    int span;
    logic [CHAN_W-1:0] b, g, r, a;
    repeat (count) begin
      span = int'(tol_level) + int'(smooth_level) + 2;
      if ($urandom_range(0, 9) < 4) begin
        b = CHAN_W'($urandom_range(0, 255));
        g = CHAN_W'($urandom_range(0, 255));
        r = CHAN_W'($urandom_range(0, 255));
      end else begin
        b = near_channel(int'(key_blue),  span);
        g = near_channel(int'(key_green), span);
        r = near_channel(int'(key_red),   span);
      end
      case ($urandom_range(0, 7))
        0:       a = '0;
        1:       a = '1;
        default: a = CHAN_W'($urandom_range(0, 255));
      endcase
      add_pixel(b, g, r, a);
    end
  endtask

  // Waits until every pixel is sent and every keyed pixel is back, then lets the
  // pipeline settle for its full latency so that registers can be changed safely.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_pixels.size() != 0 || start || keyed_expect.size() != 0);
    repeat (CK_LATENCY + 2) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [CHAN_W-1:0] tol, smooth;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset key: pure green, tolerance 26, smoothing 26, so inner 2028 and outer 8112.
    add_pixel(8'd0,   8'd255, 8'd0,   8'd255); // on the key: cleared
    add_pixel(8'd0,   8'd255, 8'd0,   8'd0);   // on the key with zero alpha
    add_pixel(8'd26,  8'd229, 8'd26,  8'd255); // exactly on the inner radius: scaled to 0
    add_pixel(8'd27,  8'd229, 8'd26,  8'd255); // just past the inner radius
    add_pixel(8'd51,  8'd203, 8'd52,  8'd255); // just inside the outer radius
    add_pixel(8'd52,  8'd203, 8'd52,  8'd200); // exactly on the outer radius: kept
    add_pixel(8'd255, 8'd0,   8'd255, 8'h5A);  // farthest corner: kept
    wait_idle();

    // Writes past the last register must leave the key alone, which the next batch of
    // pixels under the reset key confirms.
    write_reg(FIRST_UNUSED_IDX, CHAN_W'($urandom_range(0, 255)));
    write_reg(LAST_UNUSED_IDX,  8'hFF);
    write_reg(REG_IDX_W'(FIRST_UNUSED_IDX + 1), 8'h00);
    add_random(240);
    wait_idle();

    // Zero tolerance: nothing is cleared, but the soft band still scales.
    program_key(8'd200, 8'd10, 8'd100, 8'd0, 8'd40);
    add_pixel(8'd100, 8'd10, 8'd200, 8'd255);  // on the key: scaled to 0
    add_pixel(8'd100, 8'd10, 8'd201, 8'd255);  // one step away
    add_pixel(8'd139, 8'd50, 8'd240, 8'd255);  // just inside the outer radius
    add_pixel(8'd140, 8'd50, 8'd240, 8'd255);  // on the outer radius: kept
    add_random(200);
    wait_idle();

    // Zero soft band: inner equals outer, so each pixel is either cleared or kept.
    program_key(8'd128, 8'd128, 8'd128, 8'd30, 8'd0);
    add_pixel(8'd158, 8'd158, 8'd158, 8'd255); // on the shared radius: kept
    add_pixel(8'd157, 8'd158, 8'd158, 8'd255); // just inside: cleared
    add_pixel(8'd128, 8'd128, 8'd128, 8'd77);  // on the key: cleared
    add_random(200);
    wait_idle();

    // Both radii zero: every pixel passes unchanged, even on the key.
    program_key(8'h55, 8'hAA, 8'h55, 8'd0, 8'd0);
    add_pixel(8'h55, 8'hAA, 8'h55, 8'd255);
    add_random(150);
    wait_idle();

    // Largest settings: white key, tolerance and smoothing at full scale.
    program_key(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    add_pixel(8'd0,   8'd0,   8'd0,   8'd255); // farthest pixel sits on the inner radius
    add_pixel(8'd255, 8'd255, 8'd255, 8'd255); // on the key: cleared
    add_pixel(8'd0,   8'd0,   8'd1,   8'd255); // just inside the inner radius
    add_random(200);
    wait_idle();

    // Random keys. Radii are mostly modest so that the key neighborhood stays inside the
    // byte range, with the odd full-range draw.
    repeat (6) begin
      tol    = CHAN_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 60));
      smooth = CHAN_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 60));
      program_key(CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
                  CHAN_W'($urandom_range(0, 255)), tol, smooth);
      add_random(140);
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
